// ----- design/pidaw_pkg.sv -----
// Package for the PID error update block with integral clamp.
// Types, register indexes, opcodes and the fixed-point helper functions.
// No dependencies.
`default_nettype none

package pidaw_pkg;

   localparam int ERR_W   = 32;
   localparam int COEF_W  = 32;
   localparam int INTEG_W = 40;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int OUT_W   = 32;
   localparam int CSR_W   = 40;
   localparam int FRAC_W  = 16;

   localparam int PROD_W  = 72;   // widest exact product, sign extended
   localparam int QUOT_W  = PROD_W - FRAC_W;
   localparam int TERM_P_W = COEF_W + ERR_W - FRAC_W;
   localparam int TERM_I_W = COEF_W + INTEG_W - FRAC_W;
   localparam int TERM_D_W = COEF_W + DIFF_W - FRAC_W;
   localparam int SUM_W    = TERM_I_W + 2;

   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
   localparam logic signed [OUT_W-1:0]   OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0]   OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_CLEAR  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      CSR_KP       = 3'd0,
      CSR_KI_DT    = 3'd1,
      CSR_KD_RATE  = 3'd2,
      CSR_INT_HIGH = 3'd3,
      CSR_INT_LOW  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0]  kp;
      logic signed [COEF_W-1:0]  ki_dt;
      logic signed [COEF_W-1:0]  kd_rate;
      logic signed [INTEG_W-1:0] integral_high;
      logic signed [INTEG_W-1:0] integral_low;
   } cfg_type;

   // operands after the integrator
   typedef struct packed {
      logic signed [ERR_W-1:0]   err;
      logic signed [INTEG_W-1:0] isum;
      logic signed [DIFF_W-1:0]  diff;
   } integ_type;

   // raw products; the integral product is split at the binary point
   typedef struct packed {
      logic signed [COEF_W+ERR_W-1:0]            p;
      logic signed [COEF_W+INTEG_W-FRAC_W-1:0]   i_hi;
      logic signed [COEF_W+FRAC_W:0]             i_lo;
      logic signed [COEF_W+DIFF_W-1:0]           d;
   } prod_type;

   typedef struct packed {
      logic signed [TERM_P_W-1:0] p;
      logic signed [TERM_I_W-1:0] i;
      logic signed [TERM_D_W-1:0] d;
   } term_type;

   // divide by 2^16, rounding toward zero
   function automatic logic signed [QUOT_W-1:0] trunc_q16(input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W-1:0] q;
      q = x >>> FRAC_W;
      if (x[PROD_W-1] && (|x[FRAC_W-1:0])) begin
         q = q + PROD_W'(1);
      end
      return q[QUOT_W-1:0];
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] x);
      logic [SUM_W-OUT_W:0] top;
      top = x[SUM_W-1:OUT_W-1];
      if ((&top) || !(|top)) begin
         return x[OUT_W-1:0];
      end else if (x[SUM_W-1]) begin
         return OUT_MIN;
      end else begin
         return OUT_MAX;
      end
   endfunction

endpackage

`default_nettype wire

// ----- design/pid_error_update_antiwindup.sv -----
// PID error update with integral clamp, Q15.16 fixed point.
// Registers in order: input, integrator, product, term, result. The integral update
// and clamp are combinational. Throughput: one item per cycle while rsp_stall is low.
// A clear transfer updates state and produces no result.
// Synchronous active-high reset clears gains, limits, integral and previous error.
`default_nettype none

module pid_error_update_antiwindup
   import pidaw_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write,
   input  wire logic [2:0]              csr_index,
   input  wire logic [CSR_W-1:0]        csr_wdata,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_op,
   input  wire logic signed [ERR_W-1:0] req_error,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [OUT_W-1:0]      rsp_drive,
   output logic signed [OUT_W-1:0]      rsp_p_term,
   output logic signed [OUT_W-1:0]      rsp_i_term,
   output logic signed [OUT_W-1:0]      rsp_d_term
);

   cfg_type   cfg_ff;
   logic      integ_valid, mult_ready, term_valid, out_ready;
   integ_type integ_data;
   term_type  term_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_KP:       cfg_ff.kp            <= csr_wdata[COEF_W-1:0];
            CSR_KI_DT:    cfg_ff.ki_dt         <= csr_wdata[COEF_W-1:0];
            CSR_KD_RATE:  cfg_ff.kd_rate       <= csr_wdata[COEF_W-1:0];
            CSR_INT_HIGH: cfg_ff.integral_high <= csr_wdata[INTEG_W-1:0];
            CSR_INT_LOW:  cfg_ff.integral_low  <= csr_wdata[INTEG_W-1:0];
            default: ;
         endcase
      end
   end

   pidaw_integ u_integ (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .req_error (req_error),
      .cfg       (cfg_ff),
      .out_valid (integ_valid),
      .out_data  (integ_data),
      .out_ready (mult_ready)
   );

   pidaw_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (integ_valid),
      .in_data   (integ_data),
      .in_ready  (mult_ready),
      .out_valid (term_valid),
      .out_data  (term_data),
      .out_ready (out_ready)
   );

   pidaw_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (term_valid),
      .in_data    (term_data),
      .in_ready   (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_drive  (rsp_drive),
      .rsp_p_term (rsp_p_term),
      .rsp_i_term (rsp_i_term),
      .rsp_d_term (rsp_d_term)
   );

endmodule

`default_nettype wire

// ----- design/pidaw_integ.sv -----
// Input register, integral accumulator with clamp, and previous error.
// Depends on pidaw_pkg.
`default_nettype none

module pidaw_integ
   import pidaw_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_op,
   input  wire logic signed [ERR_W-1:0]  req_error,
   input  wire cfg_type                  cfg,
   output logic                          out_valid,
   output integ_type                     out_data,
   input  wire logic                     out_ready
);

   logic                      in_valid_ff;
   op_type                    in_op_ff;
   logic signed [ERR_W-1:0]   in_error_ff;
   logic signed [INTEG_W-1:0] integral_ff, integral_in;
   logic signed [ERR_W-1:0]   prev_ff;
   logic                      s1_valid_ff;
   integ_type                 s1_ff, s1_in;
   logic                      s1_en, in_en, fire;
   logic signed [INTEG_W:0]   sum_ext;

   assign s1_en     = !s1_valid_ff || out_ready;
   assign in_en     = !in_valid_ff || s1_en;
   assign req_stall = !in_en;
   assign fire      = in_valid_ff && s1_en;

   always_comb begin
      sum_ext = {integral_ff[INTEG_W-1], integral_ff}
              + {{(INTEG_W+1-ERR_W){in_error_ff[ERR_W-1]}}, in_error_ff};
      s1_in.err = in_error_ff;
      if (sum_ext[INTEG_W] != sum_ext[INTEG_W-1]) begin
         s1_in.isum = sum_ext[INTEG_W] ? INTEG_MIN : INTEG_MAX;
      end else begin
         s1_in.isum = sum_ext[INTEG_W-1:0];
      end
      s1_in.diff = {in_error_ff[ERR_W-1], in_error_ff} - {prev_ff[ERR_W-1], prev_ff};
      if (s1_in.isum > cfg.integral_high) begin
         integral_in = cfg.integral_high;
      end else if (s1_in.isum < cfg.integral_low) begin
         integral_in = cfg.integral_low;
      end else begin
         integral_in = s1_in.isum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         integral_ff <= '0;
         prev_ff     <= '0;
      end else begin
         if (in_en) begin
            in_valid_ff <= req_valid;
         end
         if (s1_en) begin
            s1_valid_ff <= in_valid_ff && (in_op_ff == OP_UPDATE);
         end
         if (fire) begin
            if (in_op_ff == OP_CLEAR) begin
               integral_ff <= '0;
               prev_ff     <= '0;
            end else begin
               integral_ff <= integral_in;
               prev_ff     <= in_error_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_en) begin
         in_op_ff    <= op_type'(req_op);
         in_error_ff <= req_error;
      end
      if (fire && (in_op_ff == OP_UPDATE)) begin
         s1_ff <= s1_in;
      end
   end

   assign out_valid = s1_valid_ff;
   assign out_data  = s1_ff;

endmodule

`default_nettype wire

// ----- design/pidaw_mult.sv -----
// Product stage and term stage: three gain products, each scaled by 2^-16
// with rounding toward zero. Depends on pidaw_pkg.
`default_nettype none

module pidaw_mult
   import pidaw_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      in_valid,
   input  wire integ_type in_data,
   output logic           in_ready,
   output logic           out_valid,
   output term_type       out_data,
   input  wire logic      out_ready
);

   logic     prod_valid_ff, term_valid_ff;
   prod_type prod_ff, prod_in;
   term_type term_ff, term_in;
   logic     prod_en, term_en;

   assign term_en  = !term_valid_ff || out_ready;
   assign prod_en  = !prod_valid_ff || term_en;
   assign in_ready = prod_en;

   always_comb begin
      prod_in.p    = cfg.kp * in_data.err;
      prod_in.i_hi = cfg.ki_dt * $signed(in_data.isum[INTEG_W-1:FRAC_W]);
      prod_in.i_lo = cfg.ki_dt * $signed({1'b0, in_data.isum[FRAC_W-1:0]});
      prod_in.d    = cfg.kd_rate * in_data.diff;
   end

   always_comb begin
      logic signed [PROD_W-1:0] i_full;
      logic signed [QUOT_W-1:0] qp, qi, qd;
      i_full = {prod_ff.i_hi, {FRAC_W{1'b0}}}
             + {{(PROD_W-COEF_W-FRAC_W-1){prod_ff.i_lo[COEF_W+FRAC_W]}}, prod_ff.i_lo};
      qp = trunc_q16({{(PROD_W-COEF_W-ERR_W){prod_ff.p[COEF_W+ERR_W-1]}}, prod_ff.p});
      qi = trunc_q16(i_full);
      qd = trunc_q16({{(PROD_W-COEF_W-DIFF_W){prod_ff.d[COEF_W+DIFF_W-1]}}, prod_ff.d});
      term_in.p = qp[TERM_P_W-1:0];
      term_in.i = qi[TERM_I_W-1:0];
      term_in.d = qd[TERM_D_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         term_valid_ff <= 1'b0;
      end else begin
         if (prod_en) begin
            prod_valid_ff <= in_valid;
         end
         if (term_en) begin
            term_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_en && in_valid) begin
         prod_ff <= prod_in;
      end
      if (term_en && prod_valid_ff) begin
         term_ff <= term_in;
      end
   end

   assign out_valid = term_valid_ff;
   assign out_data  = term_ff;

endmodule

`default_nettype wire

// ----- design/pidaw_out.sv -----
// Result stage: sums the three terms and saturates everything to 32 bits.
// Depends on pidaw_pkg.
`default_nettype none

module pidaw_out
   import pidaw_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire term_type                in_data,
   output logic                         in_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [OUT_W-1:0]      rsp_drive,
   output logic signed [OUT_W-1:0]      rsp_p_term,
   output logic signed [OUT_W-1:0]      rsp_i_term,
   output logic signed [OUT_W-1:0]      rsp_d_term
);

   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] drive_ff, p_ff, i_ff, d_ff;
   logic signed [SUM_W-1:0] p_ext, i_ext, d_ext, sum;
   logic                    en;

   assign en       = !rsp_valid_ff || !rsp_stall;
   assign in_ready = en;

   always_comb begin
      p_ext = {{(SUM_W-TERM_P_W){in_data.p[TERM_P_W-1]}}, in_data.p};
      i_ext = {{(SUM_W-TERM_I_W){in_data.i[TERM_I_W-1]}}, in_data.i};
      d_ext = {{(SUM_W-TERM_D_W){in_data.d[TERM_D_W-1]}}, in_data.d};
      sum   = p_ext + i_ext + d_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         drive_ff <= sat_out(sum);
         p_ff     <= sat_out(p_ext);
         i_ff     <= sat_out(i_ext);
         d_ff     <= sat_out(d_ext);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_drive  = drive_ff;
   assign rsp_p_term = p_ff;
   assign rsp_i_term = i_ff;
   assign rsp_d_term = d_ff;

endmodule

`default_nettype wire

// ----- dv/pid_error_update_antiwindup_test.sv -----
// Self-checking testbench for pid_error_update_antiwindup: queue-fed driver, stalling monitor,
// and a cycle-free predictor of the PID terms with integral clamp.
// Depends on pidaw_pkg and the pid_error_update_antiwindup RTL.
module pid_error_update_antiwindup_test;
   import pidaw_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 12;

   typedef logic signed [79:0] wide_t;

   typedef struct {
      op_type                  op;
      logic signed [ERR_W-1:0] error;
   } sample_t;

   typedef struct {
      logic signed [OUT_W-1:0] drive;
      logic signed [OUT_W-1:0] p_term;
      logic signed [OUT_W-1:0] i_term;
      logic signed [OUT_W-1:0] d_term;
   } terms_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write = 1'b0;
   logic [2:0]              csr_index = '0;
   logic [CSR_W-1:0]        csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_op = 1'b0;
   logic signed [ERR_W-1:0] req_error = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_drive;
   logic signed [OUT_W-1:0] rsp_p_term;
   logic signed [OUT_W-1:0] rsp_i_term;
   logic signed [OUT_W-1:0] rsp_d_term;

   pid_error_update_antiwindup u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_op     (req_op),
      .req_error  (req_error),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_drive  (rsp_drive),
      .rsp_p_term (rsp_p_term),
      .rsp_i_term (rsp_i_term),
      .rsp_d_term (rsp_d_term)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // controller copy: gains, limits and state
   logic signed [COEF_W-1:0]  m_kp = '0;
   logic signed [COEF_W-1:0]  m_ki_dt = '0;
   logic signed [COEF_W-1:0]  m_kd_rate = '0;
   logic signed [INTEG_W-1:0] m_int_high = '0;
   logic signed [INTEG_W-1:0] m_int_low = '0;
   logic signed [INTEG_W-1:0] m_integral = '0;
   logic signed [ERR_W-1:0]   m_prev_error = '0;

   sample_t pending_samples[$];
   terms_t  predicted_terms[$];
   int      mismatch_count = 0;

   // exact product of two Q16 values, rounded toward zero
   function automatic wide_t q16_product(input wide_t a, input wide_t b);
      wide_t prod;
      prod = a * b;
      return prod / 80'sd65536;
   endfunction

   function automatic logic signed [OUT_W-1:0] limit_to_word(input wide_t v);
      if (v > wide_t'(OUT_MAX)) begin
         return OUT_MAX;
      end else if (v < wide_t'(OUT_MIN)) begin
         return OUT_MIN;
      end
      return v[OUT_W-1:0];
   endfunction

   task automatic advance_controller(input op_type op, input logic signed [ERR_W-1:0] err);
      wide_t  acc;
      wide_t  p;
      wide_t  i;
      wide_t  d;
      wide_t  diff;
      terms_t res;
      if (op == OP_CLEAR) begin
         m_integral = '0;
         m_prev_error = '0;
      end else begin
         acc = m_integral;
         acc = acc + err;
         if (acc > wide_t'(INTEG_MAX)) begin
            acc = INTEG_MAX;
         end else if (acc < wide_t'(INTEG_MIN)) begin
            acc = INTEG_MIN;
         end
         m_integral = acc[INTEG_W-1:0];
         diff = err;
         diff = diff - m_prev_error;
         p = q16_product(m_kp, err);
         i = q16_product(m_ki_dt, m_integral);
         d = q16_product(m_kd_rate, diff);
         res.drive  = limit_to_word(p + i + d);
         res.p_term = limit_to_word(p);
         res.i_term = limit_to_word(i);
         res.d_term = limit_to_word(d);
         predicted_terms.push_back(res);
         m_prev_error = err;
         if (m_integral > m_int_high) begin
            m_integral = m_int_high;
         end else if (m_integral < m_int_low) begin
            m_integral = m_int_low;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                  input logic [OUT_W-1:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      mismatch_count++;
   endtask

   // driver: bursts of random length separated by random gaps
   int      gap_left = 0;
   int      burst_left = 0;
   sample_t next_sample;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_controller(op_type'(req_op), req_error);
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               next_sample = pending_samples.pop_front();
               req_valid <= 1'b1;
               req_op <= next_sample.op;
               req_error <= next_sample.error;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 31);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern
   int unsigned stall_tick = 0;
   int          stall_mode = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_tick = 0;
         stall_mode = 0;
      end else begin
         stall_tick++;
         if (stall_tick % 53 == 0) begin
            stall_mode = $urandom_range(0, 3);
         end
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= ((stall_tick & 4) != 0);
            end
         endcase
      end
   end

   // monitor
   terms_t want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_terms.size() == 0) begin
            report_mismatch("result with no prediction", rsp_drive, '0);
         end else begin
            want = predicted_terms.pop_front();
            if (rsp_drive !== want.drive) report_mismatch("drive", rsp_drive, want.drive);
            if (rsp_p_term !== want.p_term) report_mismatch("p_term", rsp_p_term, want.p_term);
            if (rsp_i_term !== want.i_term) report_mismatch("i_term", rsp_i_term, want.i_term);
            if (rsp_d_term !== want.d_term) report_mismatch("d_term", rsp_d_term, want.d_term);
         end
      end
   end

   // watchdog on cycles without any transfer
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_register(input csr_index_type idx, input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_KP:       m_kp = value[COEF_W-1:0];
         CSR_KI_DT:    m_ki_dt = value[COEF_W-1:0];
         CSR_KD_RATE:  m_kd_rate = value[COEF_W-1:0];
         CSR_INT_HIGH: m_int_high = value[INTEG_W-1:0];
         CSR_INT_LOW:  m_int_low = value[INTEG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic signed [COEF_W-1:0] kp,
                            input logic signed [COEF_W-1:0] ki_dt,
                            input logic signed [COEF_W-1:0] kd_rate,
                            input logic signed [INTEG_W-1:0] high,
                            input logic signed [INTEG_W-1:0] low);
      write_register(CSR_KP, CSR_W'(kp));
      write_register(CSR_KI_DT, CSR_W'(ki_dt));
      write_register(CSR_KD_RATE, CSR_W'(kd_rate));
      write_register(CSR_INT_HIGH, high);
      write_register(CSR_INT_LOW, low);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic add_sample(input op_type op, input logic signed [ERR_W-1:0] err);
      sample_t s;
      s.op = op;
      s.error = err;
      pending_samples.push_back(s);
   endtask

   // sender holds off until every predicted result has drained
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_samples.size() != 0 || req_valid || predicted_terms.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic signed [COEF_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return '0;
         3: return 32'sh00010000;
         4: return $signed(32'($urandom_range(0, 32'h7ffff))) - 32'sh40000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [INTEG_W-1:0] pick_limit();
      logic signed [INTEG_W-1:0] span;
      span = INTEG_W'($urandom_range(0, 32'h7fffffff));
      case ($urandom_range(0, 5))
         0: return INTEG_MAX;
         1: return INTEG_MIN;
         2: return '0;
         3: return ($urandom_range(0, 1) == 1) ? span : -span;
         default: return INTEG_W'({$urandom, $urandom});
      endcase
   endfunction

   function automatic logic signed [ERR_W-1:0] pick_error();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return '0;
         3: return $signed(32'($urandom_range(0, 512))) - 32'sd256;
         4: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(input int count);
      logic signed [INTEG_W-1:0] high;
      logic signed [INTEG_W-1:0] low;
      logic signed [INTEG_W-1:0] tmp;
      high = pick_limit();
      low = pick_limit();
      if ($urandom_range(0, 3) != 0 && low > high) begin
         tmp = low;
         low = high;
         high = tmp;
      end
      configure(pick_gain(), pick_gain(), pick_gain(), high, low);
      @(negedge clock);
      repeat (count) begin
         if ($urandom_range(0, 11) == 0) begin
            add_sample(OP_CLEAR, $urandom);
         end else begin
            add_sample(OP_UPDATE, pick_error());
         end
      end
      wait_idle();
   endtask

   // long runs of one extreme drive the accumulator into its 40 bit saturation
   task automatic windup_phase(input logic signed [ERR_W-1:0] extreme, input int count);
      add_sample(OP_CLEAR, $urandom);
      repeat (count) begin
         add_sample(OP_UPDATE, ($urandom_range(0, 19) == 0) ? pick_error() : extreme);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // moderate gains, symmetric clamp
      configure(32'sh00010000, 32'sh00008000, 32'sh00020000, 40'sd6553600, -40'sd6553600);
      @(negedge clock);
      add_sample(OP_UPDATE, 32'sd0);
      add_sample(OP_UPDATE, 32'sh7fffffff);
      add_sample(OP_UPDATE, 32'sh7fffffff);
      add_sample(OP_UPDATE, 32'sh80000000);
      add_sample(OP_UPDATE, 32'sh80000000);
      add_sample(OP_UPDATE, -32'sd1);
      add_sample(OP_UPDATE, 32'sd1);
      add_sample(OP_CLEAR, 32'sh5a5a5a5a);
      add_sample(OP_UPDATE, 32'sh12345678);
      add_sample(OP_UPDATE, -32'sh8765);
      wait_idle();

      // extreme gains, lower limit above upper limit
      configure(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, -40'sd6553600, 40'sd6553600);
      @(negedge clock);
      add_sample(OP_UPDATE, 32'sh7fffffff);
      add_sample(OP_UPDATE, 32'sh80000000);
      add_sample(OP_UPDATE, 32'sh7fffffff);
      add_sample(OP_UPDATE, 32'sd0);
      add_sample(OP_UPDATE, -32'sd1);
      add_sample(OP_CLEAR, 32'shffffffff);
      add_sample(OP_UPDATE, 32'sh80000000);
      add_sample(OP_UPDATE, 32'sd1);
      wait_idle();

      // opposite extreme gains, widest clamp
      configure(32'sh80000000, 32'sh7fffffff, 32'sh80000000, INTEG_MAX, INTEG_MIN);
      @(negedge clock);
      add_sample(OP_UPDATE, 32'sh80000000);
      add_sample(OP_UPDATE, 32'sh80000000);
      add_sample(OP_UPDATE, 32'sh7fffffff);
      add_sample(OP_UPDATE, 32'sd0);
      add_sample(OP_CLEAR, 32'sd0);
      add_sample(OP_UPDATE, 32'sh7fffffff);
      wait_idle();

      configure(32'sh00000100, 32'sd1, pick_gain(), INTEG_MAX, INTEG_MIN);
      @(negedge clock);
      windup_phase(32'sh7fffffff, 270);
      windup_phase(32'sh80000000, 270);
      wait_idle();

      repeat (6) random_phase(100);

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- pid_error_update_antiwindup.f -----
design/pidaw_pkg.sv
design/pidaw_integ.sv
design/pidaw_mult.sv
design/pidaw_out.sv
design/pid_error_update_antiwindup.sv
dv/pid_error_update_antiwindup_test.sv
